// ===== rtl/hcd_pkg.sv =====
`default_nettype none

package hcd_pkg;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [4:0] HEX_NONE = 5'd16;

    typedef enum logic [2:0] {
        PH_SIZE    = 3'd0,
        PH_DATA    = 3'd1,
        PH_TERM_CR = 3'd2,
        PH_TERM_LF = 3'd3,
        PH_STOP    = 3'd4
    } phase_t;

    typedef enum logic [2:0] {
        ST_RUNNING   = 3'd0,
        ST_FINISHED  = 3'd1,
        ST_NO_CRLF   = 3'd2,
        ST_TRUNCATED = 3'd3,
        ST_BAD_TERM  = 3'd4
    } status_t;

    // hex digit value, HEX_NONE when not a hex digit
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        v = HEX_NONE;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = {1'b0, c[3:0]};
        end
        else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
            v = {1'b0, c[3:0]} + 5'd9;
        end
        return v;
    endfunction

    // space, tab, lf, vt, ff, cr
    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/hcd_if.sv =====
`default_nettype none

interface hcd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_body;

    modport source (output valid, output in_byte, output end_of_body, input ready);
    modport sink   (input valid, input in_byte, input end_of_body, output ready);
endinterface

interface hcd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_valid;
    logic [2:0] status;
    logic       done_res;

    modport source (output valid, output out_byte, output out_valid, output status,
                    output done_res, input ready);
    modport sink   (input valid, input out_byte, input out_valid, input status,
                    input done_res, output ready);
endinterface

`default_nettype wire

// ===== rtl/http_chunked_decoder_core.sv =====
// Chunked transfer body decoder.
// in_ch carries one body byte per beat, with end_of_body on the last byte
// of a body. out_ch carries zero or one result beat per input beat: a
// payload byte (out_valid set), a final status (done_res set), or both.
// Each body ends in exactly one done_res beat unless decoding already
// stopped; bytes after a stop are swallowed until end_of_body.
// A result is registered and appears on out_ch in the cycle after its input beat.
// Throughput: one input beat per cycle while in_ch.ready is high; the size
// line, data count and terminator checks are a single state update per byte,
// and one output register holds the result.
// in_ch.ready is high whenever the output register is empty or being
// drained, so a stalled receiver holds input only while a result waits.
// Reset clears the decoder to the start of a size line and empties the
// output register. SIZE_BITS sets the chunk size counter width; a size
// that needs more bits ends decoding as finished.
`default_nettype none

module http_chunked_decoder_core
    import hcd_pkg::*;
#(
    parameter int SIZE_BITS = 32
) (
    input  wire        clk,
    input  wire        rst_n,
    hcd_in_if.sink     in_ch,
    hcd_out_if.source  out_ch
);

    localparam logic [SIZE_BITS-1:0] REM_ONE = {{(SIZE_BITS-1){1'b0}}, 1'b1};

    phase_t               phase_reg, phase_next;
    logic [SIZE_BITS-1:0] rem_reg, rem_next;
    logic                 dseen_reg, dseen_next;
    logic                 dclosed_reg, dclosed_next;
    logic                 crpend_reg, crpend_next;

    logic                 obuf_valid_reg, obuf_valid_next;
    logic [7:0]           obyte_reg;
    logic                 opay_reg;
    status_t              ostatus_reg;

    logic                 accept;
    logic                 emit;
    logic                 pay;
    logic                 boundary;
    logic                 was_stopped;
    status_t              fin;
    logic [4:0]           hv;
    logic [7:0]           b;
    logic                 eob;

    assign b      = in_ch.in_byte;
    assign eob    = in_ch.end_of_body;
    assign hv     = hex_value(b);
    assign accept = in_ch.valid && in_ch.ready;

    always_comb
    begin
        phase_next   = phase_reg;
        rem_next     = rem_reg;
        dseen_next   = dseen_reg;
        dclosed_next = dclosed_reg;
        crpend_next  = crpend_reg;
        fin          = ST_RUNNING;
        pay          = 1'b0;
        boundary     = 1'b0;
        was_stopped  = 1'b0;

        unique case (phase_reg)
            PH_SIZE:
            begin
                if (crpend_reg && b == CH_LF)
                begin
                    crpend_next = 1'b0;
                    if (!dseen_reg || rem_reg == '0)
                    begin
                        phase_next = PH_STOP;
                        fin        = ST_FINISHED;
                    end
                    else
                    begin
                        phase_next = PH_DATA;
                    end
                    dseen_next   = 1'b0;
                    dclosed_next = 1'b0;
                end
                else
                begin
                    // a lone cr is a line character: it closes digits already seen
                    if (crpend_reg && !dclosed_next && dseen_next)
                    begin
                        dclosed_next = 1'b1;
                    end
                    crpend_next = (b == CH_CR);
                    if (b != CH_CR && !dclosed_next)
                    begin
                        if (hv != HEX_NONE)
                        begin
                            if (rem_next[SIZE_BITS-1 -: 4] != 4'd0)
                            begin
                                dclosed_next = 1'b1;
                                dseen_next   = 1'b0;
                                rem_next     = '0;
                            end
                            else
                            begin
                                rem_next   = {rem_next[SIZE_BITS-5:0], hv[3:0]};
                                dseen_next = 1'b1;
                            end
                        end
                        else if (dseen_next || !is_blank(b))
                        begin
                            dclosed_next = 1'b1;
                        end
                    end
                end
            end
            PH_DATA:
            begin
                pay      = 1'b1;
                rem_next = rem_reg - REM_ONE;
                if (rem_next == '0)
                begin
                    phase_next = PH_TERM_CR;
                end
            end
            PH_TERM_CR:
            begin
                if (b == CH_CR)
                begin
                    phase_next = PH_TERM_LF;
                end
                else if (!eob)
                begin
                    phase_next = PH_STOP;
                    fin        = ST_BAD_TERM;
                end
            end
            PH_TERM_LF:
            begin
                if (b == CH_LF)
                begin
                    phase_next = PH_SIZE;
                    boundary   = 1'b1;
                end
                else
                begin
                    phase_next = PH_STOP;
                    fin        = ST_BAD_TERM;
                end
            end
            default:
            begin
                phase_next  = PH_STOP;
                was_stopped = 1'b1;
            end
        endcase

        if (eob)
        begin
            if (fin == ST_RUNNING && !was_stopped)
            begin
                if (boundary)
                begin
                    fin = ST_FINISHED;
                end
                else if (phase_next == PH_SIZE)
                begin
                    fin = ST_NO_CRLF;
                end
                else if (phase_next != PH_STOP)
                begin
                    fin = ST_TRUNCATED;
                end
            end
            phase_next   = PH_SIZE;
            rem_next     = '0;
            dseen_next   = 1'b0;
            dclosed_next = 1'b0;
            crpend_next  = 1'b0;
        end

        emit = pay || (fin != ST_RUNNING);
    end

    always_comb
    begin
        obuf_valid_next = obuf_valid_reg;
        if (accept)
        begin
            obuf_valid_next = emit;
        end
        else if (out_ch.ready)
        begin
            obuf_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_SIZE;
            rem_reg        <= '0;
            dseen_reg      <= 1'b0;
            dclosed_reg    <= 1'b0;
            crpend_reg     <= 1'b0;
            obuf_valid_reg <= 1'b0;
        end
        else
        begin
            obuf_valid_reg <= obuf_valid_next;
            if (accept)
            begin
                phase_reg   <= phase_next;
                rem_reg     <= rem_next;
                dseen_reg   <= dseen_next;
                dclosed_reg <= dclosed_next;
                crpend_reg  <= crpend_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && emit)
        begin
            obyte_reg   <= pay ? b : 8'h00;
            opay_reg    <= pay;
            ostatus_reg <= fin;
        end
    end

    assign in_ch.ready      = !obuf_valid_reg || out_ch.ready;
    assign out_ch.valid     = obuf_valid_reg;
    assign out_ch.out_byte  = obyte_reg;
    assign out_ch.out_valid = opay_reg;
    assign out_ch.status    = ostatus_reg;
    assign out_ch.done_res  = (ostatus_reg != ST_RUNNING);

endmodule

`default_nettype wire

// ===== rtl/hcd_checker.sv =====
`default_nettype none

module hcd_checker
    import hcd_pkg::*;
(
    input wire       clk,
    input wire       rst_n,
    input wire       in_ready,
    input wire       out_vld,
    input wire       out_rdy,
    input wire [7:0] out_byte,
    input wire       out_valid,
    input wire [2:0] status,
    input wire       done_res
);

    // stalled beat holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld && !out_rdy |=> out_vld && $stable(out_byte) && $stable(out_valid)
            && $stable(status) && $stable(done_res))
        else $error("stalled output beat changed");

    // done_res flags exactly the beats with a final status
    a_done_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld |-> done_res == (status != ST_RUNNING))
        else $error("done_res does not match status");

    // a beat with no payload byte is a final result with a zero byte
    a_empty_beat: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld && !out_valid |-> done_res && out_byte == 8'h00)
        else $error("empty result beat");

    // status code in range
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld |-> status <= ST_BAD_TERM)
        else $error("status code out of range");

    // input never blocked while the output register is free
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_vld || out_rdy |-> in_ready)
        else $error("input stalled with free output register");

endmodule

bind http_chunked_decoder_core hcd_checker u_hcd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ch.ready),
    .out_vld   (out_ch.valid),
    .out_rdy   (out_ch.ready),
    .out_byte  (out_ch.out_byte),
    .out_valid (out_ch.out_valid),
    .status    (out_ch.status),
    .done_res  (out_ch.done_res)
);

`default_nettype wire
